// ===== hdl/lphd_pkg.sv =====
`timescale 1ns / 1ps

package lphd_pkg;

   // Sizing of the directory.
   localparam int MAX_SLOTS_LOG2 = 16;
   localparam int ROW_REF_BITS   = 24;
   localparam int MAX_CANDIDATES = 64;

   // Fixed field widths.
   localparam int HASH_BITS      = 64;
   localparam int TAG_BITS       = 16;
   localparam int MODE_BITS      = 2;
   localparam int STATUS_BITS    = 2;
   localparam int SIZE_LOG2_BITS = 5;

   // Derived widths.
   localparam int SLOT_BITS = MAX_SLOTS_LOG2;
   localparam int CNT_BITS  = MAX_SLOTS_LOG2 + 1;
   localparam int CAND_BITS = $clog2(MAX_CANDIDATES + 1);

   // Size register limits and reset value.
   localparam logic [SIZE_LOG2_BITS-1:0] MIN_SIZE_LOG2   = SIZE_LOG2_BITS'(4);
   localparam logic [SIZE_LOG2_BITS-1:0] MAX_SIZE_LOG2   = SIZE_LOG2_BITS'(MAX_SLOTS_LOG2);
   localparam logic [SIZE_LOG2_BITS-1:0] RESET_SIZE_LOG2 = SIZE_LOG2_BITS'(16);

   // Item modes.
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_PROBE  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_TRUNC = 2'd2;

   // One slot of the directory memory.
   typedef struct packed {
      logic                    valid;
      logic [HASH_BITS-1:0]    hash;
      logic [ROW_REF_BITS-1:0] row;
   } slot_entry_type;

   // Requests from the walk controller to the slot store.
   typedef struct packed {
      logic [SLOT_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      slot_entry_type       wr_entry;
      logic                 clear_start;
   } store_cmd_type;

   // Answers from the slot store.
   typedef struct packed {
      slot_entry_type rd_entry;
      logic           clear_busy;
   } store_stat_type;

endpackage

// ===== hdl/lphd_if.sv =====
`timescale 1ns / 1ps

// Input item channel.
interface lphd_req_if import lphd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [MODE_BITS-1:0]    mode;
   logic [HASH_BITS-1:0]    hash_value;
   logic [ROW_REF_BITS-1:0] row_ref;
   logic [TAG_BITS-1:0]     item_tag;

   modport source (output valid, output mode, output hash_value, output row_ref,
                   output item_tag, input ready);
   modport sink (input valid, input mode, input hash_value, input row_ref,
                 input item_tag, output ready);
endinterface

// Result item channel.
interface lphd_rsp_if import lphd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ROW_REF_BITS-1:0] cand_row_ref;
   logic                    hit;
   logic [TAG_BITS-1:0]     result_tag;
   logic                    last;
   logic [STATUS_BITS-1:0]  status;

   modport source (output valid, output cand_row_ref, output hit, output result_tag,
                   output last, output status, input ready);
   modport sink (input valid, input cand_row_ref, input hit, input result_tag,
                 input last, input status, output ready);
endinterface

// Configuration write channel for the table size register.
interface lphd_csr_if import lphd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [SIZE_LOG2_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/lphd_slot_store.sv =====
`timescale 1ns / 1ps

module lphd_slot_store import lphd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  store_cmd_type  cmd,
   output store_stat_type stat
);

   slot_entry_type       mem [0:(1 << SLOT_BITS)-1];
   slot_entry_type       rd_entry_ff;
   logic                 clr_busy_ff;
   logic                 clr_busy_in;
   logic [SLOT_BITS-1:0] clr_addr_ff;
   logic [SLOT_BITS-1:0] clr_addr_in;
   logic                 wr_en;
   logic [SLOT_BITS-1:0] wr_addr;
   slot_entry_type       wr_entry;

   // The sweep walks every slot once, marking it empty.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {SLOT_BITS{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end else if (cmd.clear_start) begin
         clr_busy_in = 1'b1;
         clr_addr_in = '0;
      end
   end

   // The sweep owns the write port while it runs.
   always_comb begin
      if (clr_busy_ff) begin
         wr_en    = 1'b1;
         wr_addr  = clr_addr_ff;
         wr_entry = '0;
      end else begin
         wr_en    = cmd.wr_en;
         wr_addr  = cmd.wr_addr;
         wr_entry = cmd.wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[cmd.rd_addr];
   end

   assign stat.rd_entry   = rd_entry_ff;
   assign stat.clear_busy = clr_busy_ff;

endmodule

// ===== hdl/linear_probe_hash_directory_top.sv =====
`timescale 1ns / 1ps

// Linear-probing hash directory for a hash join.
// req_ch takes one item at a time: insert, probe or clear. rsp_ch returns one
// result for an insert or a clear, and one to MAX_CANDIDATES results for a
// probe, the final one marked by last. csr_ch writes the table size register;
// it is always ready, and it must be written by the user only while the block
// is idle; the block itself does not enforce this. An item is taken in the
// idle state, then the walk reads one slot per cycle through the registered
// slot memory, unless a probe walk stalls on the output register, and then a
// finish state completes the item. A new item is taken only once the last
// one is finished, so the memory read port and the cluster length set the
// rate. Probe candidates leave at most one per cycle while the receiver keeps
// up. After reset the block sweeps all 2^MAX_SLOTS_LOG2 slots empty before
// it takes the first item; a clear item runs the same sweep.
// When the receiver stalls, the result waits in the output register and a
// probe walk holds on its current slot until that register frees up.
module linear_probe_hash_directory_top import lphd_pkg::*; (
   input logic clock,
   input logic reset,
   lphd_req_if.sink   req_ch,
   lphd_rsp_if.source rsp_ch,
   lphd_csr_if.sink   csr_ch
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [SIZE_LOG2_BITS-1:0] size_log2_ff;
   logic [CNT_BITS-1:0]       entry_count_ff, entry_count_in;
   logic [MODE_BITS-1:0]      mode_ff, mode_in;
   logic [HASH_BITS-1:0]      hash_ff, hash_in;
   logic [ROW_REF_BITS-1:0]   row_ff, row_in;
   logic [TAG_BITS-1:0]       tag_ff, tag_in;
   logic [SLOT_BITS-1:0]      slot_ff, slot_in;
   logic [CNT_BITS-1:0]       steps_ff, steps_in;
   logic [CAND_BITS-1:0]      cand_cnt_ff, cand_cnt_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [ROW_REF_BITS-1:0]   pend_row_ff, pend_row_in;
   logic [STATUS_BITS-1:0]    status_ff, status_in;
   logic                      clear_item_ff, clear_item_in;

   logic                      rsp_valid_ff;
   logic [ROW_REF_BITS-1:0]   rsp_row_ff;
   logic                      rsp_hit_ff;
   logic [TAG_BITS-1:0]       rsp_tag_ff;
   logic                      rsp_last_ff;
   logic [STATUS_BITS-1:0]    rsp_status_ff;

   logic [SIZE_LOG2_BITS-1:0] eff_log2;
   logic [CNT_BITS-1:0]       size;
   logic [SLOT_BITS-1:0]      mask;
   logic [CNT_BITS:0]         count_plus_one;
   logic                      req_take;
   logic                      out_free;
   logic                      push;
   logic [ROW_REF_BITS-1:0]   push_row;
   logic                      push_hit;
   logic                      push_last;
   logic [STATUS_BITS-1:0]    push_status;
   store_cmd_type             cmd;
   store_stat_type            stat;

   lphd_slot_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // Table size in use, clamped to the supported range.
   always_comb begin
      if (size_log2_ff < MIN_SIZE_LOG2) begin
         eff_log2 = MIN_SIZE_LOG2;
      end else if (size_log2_ff > MAX_SIZE_LOG2) begin
         eff_log2 = MAX_SIZE_LOG2;
      end else begin
         eff_log2 = size_log2_ff;
      end
   end

   assign size           = {{(CNT_BITS-1){1'b0}}, 1'b1} << eff_log2;
   assign mask           = SLOT_BITS'(size - 1'b1);
   assign count_plus_one = {1'b0, entry_count_ff} + 1'b1;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Walk controller: takes an item, steps through its cluster, finishes it.
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      mode_in        = mode_ff;
      hash_in        = hash_ff;
      row_in         = row_ff;
      tag_in         = tag_ff;
      slot_in        = slot_ff;
      steps_in       = steps_ff;
      cand_cnt_in    = cand_cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_row_in    = pend_row_ff;
      status_in      = status_ff;
      clear_item_in  = clear_item_ff;
      push           = 1'b0;
      push_row       = pend_row_ff;
      push_hit       = 1'b1;
      push_last      = 1'b0;
      push_status    = STATUS_DONE;
      cmd.wr_en       = 1'b0;
      cmd.wr_addr     = slot_ff;
      cmd.wr_entry    = '{valid: 1'b1, hash: hash_ff, row: row_ff};
      cmd.clear_start = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            if (!stat.clear_busy) begin
               state_in = clear_item_ff ? ST_FINISH : ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_take) begin
               mode_in       = req_ch.mode;
               hash_in       = req_ch.hash_value;
               row_in        = req_ch.row_ref;
               tag_in        = req_ch.item_tag;
               slot_in       = req_ch.hash_value[SLOT_BITS-1:0] & mask;
               steps_in      = '0;
               cand_cnt_in   = '0;
               pend_valid_in = 1'b0;
               status_in     = STATUS_DONE;
               clear_item_in = 1'b0;
               unique case (req_ch.mode)
                  MODE_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     entry_count_in  = '0;
                     clear_item_in   = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  MODE_INSERT: begin
                     if (count_plus_one >= {1'b0, size}) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_FINISH;
                     end else begin
                        state_in = ST_EVAL;
                     end
                  end
                  MODE_PROBE: begin
                     state_in = (entry_count_ff == '0) ? ST_FINISH : ST_EVAL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_EVAL: begin
            if (mode_ff == MODE_INSERT) begin
               // Insert: stop at the first empty slot, or give up after one pass.
               if (steps_ff == size) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_FINISH;
               end else if (!stat.rd_entry.valid) begin
                  cmd.wr_en      = 1'b1;
                  entry_count_in = entry_count_ff + 1'b1;
                  state_in       = ST_FINISH;
               end else begin
                  slot_in  = (slot_ff + 1'b1) & mask;
                  steps_in = steps_ff + 1'b1;
               end
            end else begin
               // Probe: the newest candidate is held back so that the final
               // one can carry last and the status.
               if (steps_ff == size || !stat.rd_entry.valid) begin
                  state_in = ST_FINISH;
               end else if (stat.rd_entry.hash == hash_ff) begin
                  if (cand_cnt_ff >= CAND_BITS'(MAX_CANDIDATES)) begin
                     status_in = STATUS_TRUNC;
                     state_in  = ST_FINISH;
                  end else if (!pend_valid_ff || out_free) begin
                     push          = pend_valid_ff;
                     pend_valid_in = 1'b1;
                     pend_row_in   = stat.rd_entry.row;
                     cand_cnt_in   = cand_cnt_ff + 1'b1;
                     slot_in       = (slot_ff + 1'b1) & mask;
                     steps_in      = steps_ff + 1'b1;
                  end
               end else begin
                  slot_in  = (slot_ff + 1'b1) & mask;
                  steps_in = steps_ff + 1'b1;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               push        = 1'b1;
               push_row    = pend_valid_ff ? pend_row_ff : '0;
               push_hit    = pend_valid_ff;
               push_last   = 1'b1;
               push_status = status_ff;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The memory always reads the slot that the walk looks at next cycle.
      cmd.rd_addr = slot_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         entry_count_ff <= '0;
         pend_valid_ff  <= 1'b0;
         clear_item_ff  <= 1'b0;
         size_log2_ff   <= RESET_SIZE_LOG2;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         pend_valid_ff  <= pend_valid_in;
         clear_item_ff  <= clear_item_in;
         if (csr_ch.valid && csr_ch.ready) begin
            size_log2_ff <= csr_ch.data;
         end
      end
   end

   // Item and walk payload registers.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      hash_ff     <= hash_in;
      row_ff      <= row_in;
      tag_ff      <= tag_in;
      slot_ff     <= slot_in;
      steps_ff    <= steps_in;
      cand_cnt_ff <= cand_cnt_in;
      pend_row_ff <= pend_row_in;
      status_ff   <= status_in;
   end

   // Output register: holds one result item until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_row_ff    <= push_row;
         rsp_hit_ff    <= push_hit;
         rsp_tag_ff    <= tag_ff;
         rsp_last_ff   <= push_last;
         rsp_status_ff <= push_status;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.cand_row_ref = rsp_row_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.result_tag   = rsp_tag_ff;
   assign rsp_ch.last         = rsp_last_ff;
   assign rsp_ch.status       = rsp_status_ff;

endmodule
